// ===== sv/msp_pkg.sv =====
package msp_pkg;

   localparam int STACK_DEPTH = 64;
   localparam int WORD_W      = 32;
   localparam int FILL_W      = 7;
   localparam int COUNT_W     = $clog2(STACK_DEPTH + 1);
   localparam int LEVELS      = $clog2(STACK_DEPTH);

   typedef logic signed [WORD_W-1:0] word_type;

   localparam word_type EMPTY_ANSWER = '1;

   typedef enum logic [1:0] {
      OP_PUSH   = 2'd0,
      OP_POP    = 2'd1,
      OP_POPMAX = 2'd2,
      OP_QUERY  = 2'd3
   } op_type;

   // What one cell does in a cycle: refresh its running maximum, take the
   // entry of the cell above it (push) or take the entry of the cell below it.
   typedef enum logic [1:0] {
      CELL_RELAX,
      CELL_PUSH,
      CELL_POP
   } cell_op_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_SETTLE,
      ST_REPLY
   } state_type;

   // One stack entry and the largest value among it and all older entries.
   typedef struct packed {
      logic     occ;
      word_type value;
      word_type runmax;
   } cell_data_type;

   function automatic word_type smax(input word_type a, input word_type b);
      return (a >= b) ? a : b;
   endfunction

endpackage

// ===== sv/msp_cell.sv =====
module msp_cell (
   input  logic                  clock,
   input  logic                  reset,
   input  msp_pkg::cell_op_type  cell_op,
   input  msp_pkg::cell_data_type up_data,
   input  msp_pkg::cell_data_type dn_data,
   input  msp_pkg::word_type     max_bcast,
   output msp_pkg::cell_data_type cur_data,
   output logic                  match
);
   import msp_pkg::*;

   logic     occ_ff, occ_in;
   word_type value_ff, value_in;
   word_type runmax_ff, runmax_in;

   always_comb begin
      occ_in    = occ_ff;
      value_in  = value_ff;
      runmax_in = dn_data.occ ? smax(value_ff, dn_data.runmax) : value_ff;
      case (cell_op)
         CELL_PUSH: begin
            occ_in    = up_data.occ;
            value_in  = up_data.value;
            runmax_in = occ_ff ? smax(up_data.runmax, runmax_ff) : up_data.runmax;
         end
         CELL_POP: begin
            occ_in    = dn_data.occ;
            value_in  = dn_data.value;
            runmax_in = dn_data.runmax;
         end
         default: begin
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         occ_ff <= 1'b0;
      end else begin
         occ_ff <= occ_in;
      end
   end

   always_ff @(posedge clock) begin
      value_ff  <= value_in;
      runmax_ff <= runmax_in;
   end

   assign cur_data = '{occ: occ_ff, value: value_ff, runmax: runmax_ff};
   assign match    = occ_ff && (value_ff == max_bcast);

endmodule

// ===== sv/max_stack_with_popmax_top.sv =====
// Sequence: a transferred request passes an execute state and then a reply state, and its
// result is registered once the output register is free; a pop of the maximum adds a settling
// state between them, which waits for the neighbor-to-neighbor refresh of running maxima. A new
// request transfers only when the previous result goes to the output register, not before.
// Reset (synchronous, active high) empties the stack and drops any pending result;
// stored entry values are not cleared.
module max_stack_with_popmax_top (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [1:0]                    req_operation,
   input  logic signed [31:0]            req_push_value,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic signed [31:0]            rsp_removed_value,
   output logic signed [31:0]            rsp_top_value,
   output logic signed [31:0]            rsp_max_value,
   output logic [6:0]                    rsp_fill_count,
   output logic                          rsp_is_empty,
   output logic                          rsp_op_failed
);
   import msp_pkg::*;

   // The stack is a row of cells with the top entry in cell 0. Each cell also keeps
   // the largest value among itself and every older entry, so cell 0 always holds
   // the overall maximum once the row has settled. Push shifts the row down by one,
   // pop shifts it up. Pop maximum shifts up only the cells from the nearest-to-top
   // occurrence of the maximum downward; the newer cells keep their values, and
   // their running maxima are rebuilt by each cell looking at its lower neighbor
   // in every cycle, so the fix travels one cell per cycle toward the top.

   state_type state_ff, state_in;
   op_type    op_ff, op_in;
   word_type  val_ff, val_in;
   word_type  removed_ff, removed_in;
   logic      failed_ff, failed_in;
   logic [COUNT_W-1:0] count_ff, count_in;
   logic [COUNT_W-1:0] wait_ff, wait_in;

   logic      rsp_valid_ff, rsp_valid_in;
   word_type  rsp_removed_ff, rsp_top_ff, rsp_max_ff;
   logic [FILL_W-1:0] rsp_fill_ff;
   logic      rsp_empty_ff, rsp_failed_ff;
   logic      load;
   logic      out_free;

   cell_data_type cell_q [STACK_DEPTH];
   cell_op_type   cell_op [STACK_DEPTH];
   logic [STACK_DEPTH-1:0] match;
   logic [STACK_DEPTH-1:0] shift;
   cell_data_type head_data;
   cell_data_type tail_data;
   logic [COUNT_W+FILL_W-1:0] count_wide;

   assign head_data = '{occ: 1'b1, value: val_ff, runmax: val_ff};
   assign tail_data = '0;

   for (genvar g = 0; g < STACK_DEPTH; g++) begin : g_cell
      cell_data_type up_d;
      cell_data_type dn_d;
      if (g == 0) begin : g_head
         assign up_d = head_data;
      end else begin : g_up
         assign up_d = cell_q[g-1];
      end
      if (g == STACK_DEPTH - 1) begin : g_tail
         assign dn_d = tail_data;
      end else begin : g_dn
         assign dn_d = cell_q[g+1];
      end
      msp_cell u_cell (
         .clock     (clock),
         .reset     (reset),
         .cell_op   (cell_op[g]),
         .up_data   (up_d),
         .dn_data   (dn_d),
         .max_bcast (cell_q[0].runmax),
         .cur_data  (cell_q[g]),
         .match     (match[g])
      );
   end

   // A cell shifts up during a pop of the maximum when it, or any cell nearer the
   // top, holds the maximum. This prefix OR is built in logarithmic steps.
   always_comb begin
      shift = match;
      for (int k = 0; k < LEVELS; k++) begin
         shift = shift | (shift << (1 << k));
      end
   end

   assign out_free = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      state_in   = state_ff;
      op_in      = op_ff;
      val_in     = val_ff;
      removed_in = removed_ff;
      failed_in  = failed_ff;
      count_in   = count_ff;
      wait_in    = wait_ff;
      req_stall  = 1'b1;
      load       = 1'b0;
      for (int i = 0; i < STACK_DEPTH; i++) begin
         cell_op[i] = CELL_RELAX;
      end

      case (state_ff)
         ST_IDLE: begin
            req_stall = 1'b0;
            if (req_valid) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in   = ST_REPLY;
            removed_in = '0;
            failed_in  = 1'b0;
            case (op_ff)
               OP_PUSH: begin
                  if (count_ff == COUNT_W'(STACK_DEPTH)) begin
                     failed_in = 1'b1;
                  end else begin
                     count_in = count_ff + COUNT_W'(1);
                     for (int i = 0; i < STACK_DEPTH; i++) begin
                        cell_op[i] = CELL_PUSH;
                     end
                  end
               end
               OP_POP, OP_POPMAX: begin
                  if (count_ff == '0) begin
                     removed_in = EMPTY_ANSWER;
                     failed_in  = 1'b1;
                  end else if (op_ff == OP_POP) begin
                     removed_in = cell_q[0].value;
                     count_in   = count_ff - COUNT_W'(1);
                     for (int i = 0; i < STACK_DEPTH; i++) begin
                        cell_op[i] = CELL_POP;
                     end
                  end else begin
                     // The removed entry is the settled maximum itself.
                     removed_in = cell_q[0].runmax;
                     count_in   = count_ff - COUNT_W'(1);
                     wait_in    = count_ff - COUNT_W'(1);
                     state_in   = ST_SETTLE;
                     for (int i = 0; i < STACK_DEPTH; i++) begin
                        cell_op[i] = shift[i] ? CELL_POP : CELL_RELAX;
                     end
                  end
               end
               default: begin
               end
            endcase
         end
         ST_SETTLE: begin
            if (wait_ff == '0) begin
               state_in = ST_REPLY;
            end else begin
               wait_in = wait_ff - COUNT_W'(1);
            end
         end
         ST_REPLY: begin
            // The result goes to the output register as soon as it is free, and the
            // next request can transfer in the same cycle.
            if (out_free) begin
               load      = 1'b1;
               req_stall = 1'b0;
               state_in  = req_valid ? ST_EXEC : ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      if (req_valid && !req_stall) begin
         op_in  = op_type'(req_operation);
         val_in = req_push_value;
      end
   end

   always_comb begin
      if (load) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_stall) begin
         rsp_valid_in = rsp_valid_ff;
      end else begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         wait_ff      <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         wait_ff      <= wait_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   assign count_wide = {{FILL_W{1'b0}}, count_ff};

   always_ff @(posedge clock) begin
      op_ff      <= op_in;
      val_ff     <= val_in;
      removed_ff <= removed_in;
      failed_ff  <= failed_in;
      if (load) begin
         rsp_removed_ff <= removed_ff;
         rsp_top_ff     <= (count_ff == '0) ? EMPTY_ANSWER : cell_q[0].value;
         rsp_max_ff     <= (count_ff == '0) ? EMPTY_ANSWER : cell_q[0].runmax;
         rsp_fill_ff    <= count_wide[FILL_W-1:0];
         rsp_empty_ff   <= (count_ff == '0);
         rsp_failed_ff  <= failed_ff;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_removed_value = rsp_removed_ff;
   assign rsp_top_value     = rsp_top_ff;
   assign rsp_max_value     = rsp_max_ff;
   assign rsp_fill_count    = rsp_fill_ff;
   assign rsp_is_empty      = rsp_empty_ff;
   assign rsp_op_failed     = rsp_failed_ff;

endmodule
